[design/bpq_pkg.sv]
// Shared types and constants of the bucket priority thread queue.
`default_nettype none

package bpq_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int ID_W        = 16;
   localparam int PRIO_W      = 8;
   localparam int RANK_W      = 4;
   localparam int OP_W        = 3;
   localparam int STAT_W      = 3;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [OP_W-1:0] OP_REPRIO  = 3'd2;
   localparam logic [OP_W-1:0] OP_EXTRACT = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STAT_W-1:0] STAT_DUP      = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   thread_id;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   result_id;
      logic [PRIO_W-1:0] result_priority;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [RANK_W-1:0] rank;
   } entry_type;

   typedef struct packed {
      logic              clear;
      logic              sample;
      logic              live;
      logic [IDX_W-1:0]  idx;
      logic [ID_W-1:0]   key_id;
      logic [PRIO_W-1:0] key_prio;
   } scan_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      entry_type         hit_entry;
      logic              head_hit;
      logic [IDX_W-1:0]  head_idx;
      entry_type         head_entry;
      logic [CNT_W-1:0]  cnt;
      logic              any;
      logic [PRIO_W-1:0] min_prio;
   } scan_res_type;

endpackage

`default_nettype wire

[design/bucket_priority_thread_queue.sv]
// Top level: operation sequencer, valid bits and response register.
// Sixteen-entry thread table kept in a single-port-read memory. Every
// operation sweeps the table once, one entry a cycle with registered read
// data, then decides: search, insert and unused codes respond after this
// decision, as do a delete or reprioritize of a missing id and an extract
// from an empty queue. Otherwise delete, reprioritize and extract sweep a
// second time to renumber ranks in the affected bucket and decide again.
// busy stays high until the strobe cycle; the response shows for exactly
// that one cycle and cannot be held off, and a new start is taken in that
// same cycle.
`default_nettype none

module bucket_priority_thread_queue (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire bpq_pkg::req_type req_data,
   output logic          rsp_strobe,
   output bpq_pkg::rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_PASS1   = 5'b00010,
      S_DECIDE1 = 5'b00100,
      S_PASS2   = 5'b01000,
      S_DECIDE2 = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   bpq_pkg::req_type req_ff, req_in;
   logic [bpq_pkg::NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic [bpq_pkg::CNT_W-1:0]  addr_ff, addr_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [bpq_pkg::IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [bpq_pkg::PRIO_W-1:0] key_prio_ff, key_prio_in;
   logic [bpq_pkg::PRIO_W-1:0] dec_prio_ff, dec_prio_in;
   logic [bpq_pkg::RANK_W-1:0] dec_rank_ff, dec_rank_in;
   logic [bpq_pkg::IDX_W-1:0]  slot_ff, slot_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   bpq_pkg::rsp_type           rsp_ff, rsp_in;

   logic                       rd_en;
   logic [bpq_pkg::IDX_W-1:0]  rd_addr;
   bpq_pkg::entry_type         rd_data;
   logic                       wr_en;
   logic [bpq_pkg::IDX_W-1:0]  wr_addr;
   bpq_pkg::entry_type         wr_data;
   bpq_pkg::scan_ctl_type      scan_ctl;
   bpq_pkg::scan_res_type      scan_res;
   logic [bpq_pkg::IDX_W-1:0]  free_idx;
   logic                       table_full;

   bpq_table u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bpq_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .rd_entry (rd_data),
      .res      (scan_res)
   );

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = bpq_pkg::NUM_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = bpq_pkg::IDX_W'(i);
         end
      end
   end

   assign table_full = &valid_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      key_prio_in   = key_prio_ff;
      dec_prio_in   = dec_prio_ff;
      dec_rank_in   = dec_rank_ff;
      slot_in       = slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      rd_en   = 1'b0;
      rd_addr = addr_ff[bpq_pkg::IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data;

      scan_ctl.clear    = 1'b0;
      scan_ctl.sample   = rd_vld_ff;
      scan_ctl.live     = valid_ff[rd_idx_ff];
      scan_ctl.idx      = rd_idx_ff;
      scan_ctl.key_id   = req_ff.thread_id;
      scan_ctl.key_prio = key_prio_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in         = req_data;
               key_prio_in    = req_data.priority_req;
               addr_in        = '0;
               scan_ctl.clear = 1'b1;
               state_in       = S_PASS1;
            end
         end

         S_PASS1, S_PASS2: begin
            if (addr_ff < bpq_pkg::CNT_W'(bpq_pkg::NUM_ENTRIES)) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff[bpq_pkg::IDX_W-1:0];
               addr_in   = addr_ff + 1'b1;
            end
            // second sweep closes the rank gap in the affected bucket
            if (state_ff == S_PASS2 && rd_vld_ff && valid_ff[rd_idx_ff] &&
                rd_data.prio == dec_prio_ff && rd_data.rank > dec_rank_ff) begin
               wr_en        = 1'b1;
               wr_data.rank = rd_data.rank - 1'b1;
            end
            if (rd_vld_ff && rd_idx_ff == bpq_pkg::IDX_W'(bpq_pkg::NUM_ENTRIES - 1)) begin
               state_in = (state_ff == S_PASS1) ? S_DECIDE1 : S_DECIDE2;
            end
         end

         S_DECIDE1: begin
            rsp_in   = '0;
            state_in = S_IDLE;
            case (req_ff.op)
               bpq_pkg::OP_INSERT: begin
                  rsp_strobe_in = 1'b1;
                  if (scan_res.hit) begin
                     rsp_in.status = bpq_pkg::STAT_DUP;
                  end else if (table_full) begin
                     rsp_in.status = bpq_pkg::STAT_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     wr_addr            = free_idx;
                     wr_data.id         = req_ff.thread_id;
                     wr_data.prio       = req_ff.priority_req;
                     wr_data.rank       = scan_res.cnt[bpq_pkg::RANK_W-1:0];
                     valid_in[free_idx] = 1'b1;
                  end
               end
               bpq_pkg::OP_DELETE, bpq_pkg::OP_REPRIO: begin
                  if (!scan_res.hit) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = bpq_pkg::STAT_NOTFOUND;
                  end else begin
                     valid_in[scan_res.hit_idx] = 1'b0;
                     dec_prio_in    = scan_res.hit_entry.prio;
                     dec_rank_in    = scan_res.hit_entry.rank;
                     slot_in        = scan_res.hit_idx;
                     addr_in        = '0;
                     scan_ctl.clear = 1'b1;
                     state_in       = S_PASS2;
                  end
               end
               bpq_pkg::OP_EXTRACT: begin
                  if (!scan_res.any) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = bpq_pkg::STAT_EMPTY;
                  end else begin
                     dec_prio_in    = scan_res.min_prio;
                     dec_rank_in    = '0;
                     key_prio_in    = scan_res.min_prio;
                     addr_in        = '0;
                     scan_ctl.clear = 1'b1;
                     state_in       = S_PASS2;
                  end
               end
               bpq_pkg::OP_SEARCH: begin
                  rsp_strobe_in = 1'b1;
                  if (scan_res.hit) begin
                     rsp_in.result_id       = scan_res.hit_entry.id;
                     rsp_in.result_priority = scan_res.hit_entry.prio;
                  end else begin
                     rsp_in.status = bpq_pkg::STAT_NOTFOUND;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end

         S_DECIDE2: begin
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            case (req_ff.op)
               bpq_pkg::OP_REPRIO: begin
                  wr_en             = 1'b1;
                  wr_addr           = slot_ff;
                  wr_data.id        = req_ff.thread_id;
                  wr_data.prio      = req_ff.priority_req;
                  wr_data.rank      = scan_res.cnt[bpq_pkg::RANK_W-1:0];
                  valid_in[slot_ff] = 1'b1;
               end
               bpq_pkg::OP_EXTRACT: begin
                  if (scan_res.head_hit) begin
                     // head rotates to the tail of its bucket
                     wr_en        = 1'b1;
                     wr_addr      = scan_res.head_idx;
                     wr_data      = scan_res.head_entry;
                     wr_data.rank = bpq_pkg::RANK_W'(scan_res.cnt - 1'b1);
                     rsp_in.result_id       = scan_res.head_entry.id;
                     rsp_in.result_priority = scan_res.head_entry.prio;
                  end else begin
                     rsp_in.status = bpq_pkg::STAT_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         addr_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         addr_ff       <= addr_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      key_prio_ff <= key_prio_in;
      dec_prio_ff <= dec_prio_in;
      dec_rank_ff <= dec_rank_in;
      slot_ff     <= slot_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted start did not raise busy");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == bpq_pkg::STAT_FULL) |-> (&valid_ff))
      else $error("full status with a free slot");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == bpq_pkg::STAT_EMPTY) |-> (valid_ff == '0))
      else $error("empty status with a valid entry");

endmodule

`default_nettype wire

[design/bpq_table.sv]
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module bpq_table (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [bpq_pkg::IDX_W-1:0]     rd_addr,
   output bpq_pkg::entry_type                 rd_data,
   input  wire logic                          wr_en,
   input  wire logic [bpq_pkg::IDX_W-1:0]     wr_addr,
   input  wire bpq_pkg::entry_type            wr_data
);

   bpq_pkg::entry_type mem [bpq_pkg::NUM_ENTRIES];
   bpq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/bpq_scan.sv]
// Scan accumulator: id match, bucket count, bucket head and minimum priority.
`default_nettype none

module bpq_scan (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bpq_pkg::scan_ctl_type ctl,
   input  wire bpq_pkg::entry_type  rd_entry,
   output bpq_pkg::scan_res_type res
);

   bpq_pkg::scan_res_type res_ff;
   bpq_pkg::scan_res_type res_in;

   always_comb begin
      res_in = res_ff;
      if (ctl.clear) begin
         res_in.hit      = 1'b0;
         res_in.head_hit = 1'b0;
         res_in.any      = 1'b0;
         res_in.cnt      = '0;
      end else if (ctl.sample && ctl.live) begin
         // first match by lowest index
         if (!res_ff.hit && rd_entry.id == ctl.key_id) begin
            res_in.hit       = 1'b1;
            res_in.hit_idx   = ctl.idx;
            res_in.hit_entry = rd_entry;
         end
         if (rd_entry.prio == ctl.key_prio) begin
            res_in.cnt = res_ff.cnt + 1'b1;
            if (!res_ff.head_hit && rd_entry.rank == '0) begin
               res_in.head_hit   = 1'b1;
               res_in.head_idx   = ctl.idx;
               res_in.head_entry = rd_entry;
            end
         end
         if (!res_ff.any || rd_entry.prio < res_ff.min_prio) begin
            res_in.any      = 1'b1;
            res_in.min_prio = rd_entry.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.hit      <= 1'b0;
         res_ff.head_hit <= 1'b0;
         res_ff.any      <= 1'b0;
         res_ff.cnt      <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

[tb/sv/tb_bucket_priority_thread_queue.sv]
// Self-checking testbench for the bucket priority thread queue.
`timescale 1ns / 100ps

module tb_bucket_priority_thread_queue;

   localparam logic [bpq_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [bpq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [bpq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int ID_POOL      = 20;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 40;
   localparam int REQ_W        = $bits(bpq_pkg::req_type);

   typedef struct {
      bpq_pkg::req_type req;
      int               reps;
      bit               typed;
      bpq_pkg::rsp_type want;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   bpq_pkg::req_type req_data;
   logic             rsp_strobe;
   bpq_pkg::rsp_type rsp_data;

   // scheduler image kept by the testbench
   logic                       slot_live [bpq_pkg::NUM_ENTRIES] = '{default: 1'b0};
   logic [bpq_pkg::ID_W-1:0]   slot_id   [bpq_pkg::NUM_ENTRIES];
   logic [bpq_pkg::PRIO_W-1:0] slot_prio [bpq_pkg::NUM_ENTRIES];
   logic [bpq_pkg::RANK_W-1:0] slot_rank [bpq_pkg::NUM_ENTRIES];

   bpq_pkg::rsp_type         pending_rsp [$];
   bpq_pkg::rsp_type         oldest_rsp;
   int                       mismatches = 0;
   bit                       no_idle = 1'b0;
   logic [bpq_pkg::ID_W-1:0] id_pool [ID_POOL];

   // op mix per phase: insert, delete, reprioritize, extract, search cut points
   int op_cut [3][5] = '{'{55, 65, 75, 90, 98},
                         '{30, 45, 60, 85, 97},
                         '{15, 45, 55, 85, 97}};
   logic [bpq_pkg::OP_W-1:0] spare_ops [3] = '{OP_SPARE_5, OP_SPARE_6, OP_SPARE_7};

   plan_row_type plan [20] = '{
      '{'{bpq_pkg::OP_EXTRACT, 16'h0000, 8'h00}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_EMPTY}},
      '{'{bpq_pkg::OP_SEARCH,  16'h1234, 8'h00}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_NOTFOUND}},
      '{'{bpq_pkg::OP_DELETE,  16'h1234, 8'h00}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_NOTFOUND}},
      '{'{bpq_pkg::OP_REPRIO,  16'h1234, 8'h09}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_NOTFOUND}},
      '{'{bpq_pkg::OP_INSERT,  16'hFFFF, 8'hFF}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_OK}},
      '{'{bpq_pkg::OP_INSERT,  16'h0000, 8'h00}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_OK}},
      '{'{bpq_pkg::OP_SEARCH,  16'hFFFF, 8'h00}, 1, 1'b1,
        '{16'hFFFF, 8'hFF, bpq_pkg::STAT_OK}},
      '{'{bpq_pkg::OP_INSERT,  16'hFFFF, 8'h03}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_DUP}},
      '{'{bpq_pkg::OP_EXTRACT, 16'h0000, 8'h00}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_OK}},
      // lone entry in its bucket stays head
      '{'{bpq_pkg::OP_EXTRACT, 16'h0000, 8'h00}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_OK}},
      '{'{OP_SPARE_5, 16'hAAAA, 8'h55}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_OK}},
      '{'{OP_SPARE_7, 16'h5555, 8'hAA}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_OK}},
      '{'{bpq_pkg::OP_INSERT,  16'h0100, 8'h00}, 1, 1'b0, '0},
      '{'{bpq_pkg::OP_EXTRACT, 16'h0000, 8'h00}, 1, 1'b0, '0},
      '{'{bpq_pkg::OP_REPRIO,  16'hFFFF, 8'h00}, 1, 1'b0, '0},
      '{'{bpq_pkg::OP_EXTRACT, 16'h0000, 8'h00}, 1, 1'b0, '0},
      // fill the remaining slots
      '{'{bpq_pkg::OP_INSERT,  16'h2000, 8'h80}, 13, 1'b0, '0},
      '{'{bpq_pkg::OP_INSERT,  16'h3000, 8'h01}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_FULL}},
      // duplicate wins over full
      '{'{bpq_pkg::OP_INSERT,  16'h0100, 8'h01}, 1, 1'b1,
        '{16'h0000, 8'h00, bpq_pkg::STAT_DUP}},
      '{'{bpq_pkg::OP_DELETE,  16'h2005, 8'h00}, 1, 1'b0, '0}
   };

   bucket_priority_thread_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int bucket_size(logic [bpq_pkg::PRIO_W-1:0] p);
      int n = 0;
      for (int i = 0; i < bpq_pkg::NUM_ENTRIES; i++)
         if (slot_live[i] && slot_prio[i] == p) n++;
      return n;
   endfunction

   // drop a slot and close the gap behind it in its bucket
   function automatic void unlink(int s);
      for (int i = 0; i < bpq_pkg::NUM_ENTRIES; i++)
         if (i != s && slot_live[i] && slot_prio[i] == slot_prio[s] &&
             slot_rank[i] > slot_rank[s]) slot_rank[i]--;
      slot_live[s] = 1'b0;
   endfunction

   function automatic void park_at_tail(int s, logic [bpq_pkg::ID_W-1:0] id,
                                        logic [bpq_pkg::PRIO_W-1:0] p);
      slot_rank[s] = bpq_pkg::RANK_W'(bucket_size(p));
      slot_live[s] = 1'b1;
      slot_id[s]   = id;
      slot_prio[s] = p;
   endfunction

   function automatic bpq_pkg::rsp_type sched_step(bpq_pkg::req_type r);
      bpq_pkg::rsp_type           o;
      int                         hit;
      int                         head;
      int                         n;
      bit                         any;
      logic [bpq_pkg::PRIO_W-1:0] best;
      o    = '0;
      hit  = -1;
      head = -1;
      any  = 1'b0;
      best = '0;
      for (int i = bpq_pkg::NUM_ENTRIES - 1; i >= 0; i--)
         if (slot_live[i] && slot_id[i] == r.thread_id) hit = i;
      case (r.op)
         bpq_pkg::OP_INSERT: begin
            if (hit >= 0) begin
               o.status = bpq_pkg::STAT_DUP;
            end else begin
               for (int i = bpq_pkg::NUM_ENTRIES - 1; i >= 0; i--)
                  if (!slot_live[i]) head = i;
               if (head < 0) o.status = bpq_pkg::STAT_FULL;
               else park_at_tail(head, r.thread_id, r.priority_req);
            end
         end
         bpq_pkg::OP_DELETE: begin
            if (hit < 0) o.status = bpq_pkg::STAT_NOTFOUND;
            else unlink(hit);
         end
         bpq_pkg::OP_REPRIO: begin
            if (hit < 0) begin
               o.status = bpq_pkg::STAT_NOTFOUND;
            end else begin
               unlink(hit);
               park_at_tail(hit, r.thread_id, r.priority_req);
            end
         end
         bpq_pkg::OP_EXTRACT: begin
            for (int i = 0; i < bpq_pkg::NUM_ENTRIES; i++)
               if (slot_live[i] && (!any || slot_prio[i] < best)) begin
                  best = slot_prio[i];
                  any  = 1'b1;
               end
            for (int i = bpq_pkg::NUM_ENTRIES - 1; i >= 0; i--)
               if (any && slot_live[i] && slot_prio[i] == best && slot_rank[i] == '0)
                  head = i;
            if (head < 0) begin
               o.status = bpq_pkg::STAT_EMPTY;
            end else begin
               o.result_id       = slot_id[head];
               o.result_priority = slot_prio[head];
               n = bucket_size(best);
               // rotate the head to the tail of its bucket
               for (int i = 0; i < bpq_pkg::NUM_ENTRIES; i++)
                  if (i != head && slot_live[i] && slot_prio[i] == best && slot_rank[i] != '0)
                     slot_rank[i]--;
               slot_rank[head] = bpq_pkg::RANK_W'(n - 1);
            end
         end
         bpq_pkg::OP_SEARCH: begin
            if (hit < 0) begin
               o.status = bpq_pkg::STAT_NOTFOUND;
            end else begin
               o.result_id       = slot_id[hit];
               o.result_priority = slot_prio[hit];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(5, 60);
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, seen);
         mismatches++;
      end
   endfunction

   // one request transfer; called and returns at a falling edge
   task automatic issue_op(bpq_pkg::req_type r, bit typed, bpq_pkg::rsp_type typed_rsp);
      int               gap;
      bpq_pkg::rsp_type predicted;
      logic [REQ_W-1:0] noise;
      gap = pick_gap();
      if (gap > 0) begin
         noise = REQ_W'($urandom);
         start    <= 1'b0;
         req_data <= noise;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = sched_step(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            check_field("result_id", 32'(oldest_rsp.result_id),
                        32'(rsp_data.result_id));
            check_field("result_priority", 32'(oldest_rsp.result_priority),
                        32'(rsp_data.result_priority));
            check_field("status", 32'(oldest_rsp.status), 32'(rsp_data.status));
         end
      end
   end

   initial begin : stimulus
      bpq_pkg::req_type r;
      int               bias;
      int               roll;
      int               pick;
      bias     = 1;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      for (int i = 0; i < ID_POOL; i++) id_pool[i] = bpq_pkg::ID_W'($urandom);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         for (int k = 0; k < plan[i].reps; k++) begin
            r = plan[i].req;
            r.thread_id = r.thread_id + bpq_pkg::ID_W'(k);
            issue_op(r, plan[i].typed, plan[i].want);
         end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // phases lean toward filling, balancing or draining the table
         if (n % 100 == 0) begin
            bias    = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         r.op = (roll < op_cut[bias][0]) ? bpq_pkg::OP_INSERT :
                (roll < op_cut[bias][1]) ? bpq_pkg::OP_DELETE :
                (roll < op_cut[bias][2]) ? bpq_pkg::OP_REPRIO :
                (roll < op_cut[bias][3]) ? bpq_pkg::OP_EXTRACT :
                (roll < op_cut[bias][4]) ? bpq_pkg::OP_SEARCH :
                                           spare_ops[$urandom_range(0, 2)];
         r.thread_id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL - 1)]
                                                    : bpq_pkg::ID_W'($urandom);
         pick = $urandom_range(0, 99);
         r.priority_req = (pick < 50) ? bpq_pkg::PRIO_W'($urandom_range(0, 3)) :
                          (pick < 70) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) :
                                        bpq_pkg::PRIO_W'($urandom);
         issue_op(r, 1'b0, '0);
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
design/bpq_pkg.sv
design/bpq_table.sv
design/bpq_scan.sv
design/bucket_priority_thread_queue.sv
tb/sv/tb_bucket_priority_thread_queue.sv
